>>> rtl/egd_pkg.sv
// Package for the explicit grid diffusion step: field widths, register
// indexes and reset values used by explicit_grid_diffusion_step.
// No dependencies.
package egd_pkg;

    // Default largest interior size per side
    localparam int MAX_N_DEF = 254;

    // Field and register widths
    localparam int VALUE_W   = 32;
    localparam int RATE_W    = 16;
    localparam int GRID_N_W  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_N = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 8'd1;

    // Reset values of the configuration registers
    localparam logic [GRID_N_W-1:0] GRID_N_RESET = 8'd10;
    localparam logic [RATE_W-1:0]   RATE_RESET   = 16'd0;

    // Result queue depth (power of two)
    localparam int OUT_DEPTH = 16;

endpackage

>>> rtl/egd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old data.
// No dependencies.
module egd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first storage
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/explicit_grid_diffusion_step.sv
// Explicit five-point diffusion step over a streamed (n+2)x(n+2) grid.
// A result passes through stages 1 to 4 and is then written to the output queue.
// Throughput: one cell per cycle while s_ready is high; on the last row each cell gives two
// results, so the single output port paces input there.
// Reset: counters cleared, grid_n = 10, rate = 0; the two line-buffer RAMs are not cleared.
// Depends on egd_pkg and egd_ram.
module explicit_grid_diffusion_step #(
    parameter int MAX_N = egd_pkg::MAX_N_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cell input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [egd_pkg::VALUE_W-1:0]  s_cell_value,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [egd_pkg::VALUE_W-1:0]  m_new_value,
    output logic                                m_frame_last,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [egd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [egd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VW     = egd_pkg::VALUE_W;
    localparam int RW     = egd_pkg::RATE_W;
    localparam int STRIDE = MAX_N + 2;
    localparam int ADDR_W = $clog2(STRIDE);
    localparam int NW     = ((ADDR_W > egd_pkg::GRID_N_W) ? ADDR_W : egd_pkg::GRID_N_W) + 1;
    localparam int LAP_W  = VW + 3;
    localparam int PROD_W = LAP_W + RW + 1;
    localparam int Q_W    = PROD_W - 12;
    localparam int SUM_W  = Q_W + 1;
    localparam int DEPTH  = egd_pkg::OUT_DEPTH;
    localparam int QAW    = $clog2(DEPTH);

    // Index of the last row/column for a given interior size, clamped to MAX_N
    function automatic logic [ADDR_W-1:0] last_of(input logic [egd_pkg::GRID_N_W-1:0] n);
        logic [NW-1:0] nw;
        nw = NW'(n);
        if (nw > NW'(MAX_N)) begin
            nw = NW'(MAX_N);
        end
        return ADDR_W'(nw + NW'(1));
    endfunction

    // Configuration and position
    logic [ADDR_W-1:0] last_reg;
    logic [RW-1:0]     rate_reg;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic              cfg_req;
    logic              in_req;

    // Stage 1 (RAM data returns)
    logic          s1_valid_reg;
    logic          s1_has_reg, s1_border_reg, s1_emit2_reg, s1_flast_reg;
    logic          s1_col0_reg, s1_par_reg;
    logic [VW-1:0] s1_x_reg, s1_first_reg;
    logic [VW-1:0] first_reg;
    logic [VW-1:0] win_l_reg, win_c_reg;
    logic [VW-1:0] rdata [2];
    logic [VW-1:0] up_val, right_val, cen_val;
    logic signed [LAP_W-1:0] lap_val;

    // Stage 2 (multiply)
    logic                    s2_valid_reg;
    logic                    s2_has_reg, s2_border_reg, s2_emit2_reg, s2_flast_reg;
    logic [VW-1:0]           s2_x_reg, s2_c_reg;
    logic signed [LAP_W-1:0] s2_lap_reg;

    // Stage 3 (round)
    logic                     s3_valid_reg;
    logic                     s3_has_reg, s3_border_reg, s3_emit2_reg, s3_flast_reg;
    logic [VW-1:0]            s3_x_reg, s3_c_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [PROD_W-1:0] rnd_val;

    // Stage 4 (add center, saturate, enqueue)
    logic                  s4_valid_reg;
    logic                  s4_has_reg, s4_border_reg, s4_emit2_reg, s4_flast_reg;
    logic [VW-1:0]         s4_x_reg, s4_c_reg;
    logic signed [Q_W-1:0] s4_q_reg;
    logic signed [SUM_W-1:0] sum_val;
    logic [VW-1:0]         sat_val, res_val;

    // Output queue
    logic [VW-1:0]  q_val_reg  [DEPTH];
    logic           q_last_reg [DEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr2;
    logic [QAW:0]   occ_reg, occ_next;
    logic [QAW:0]   used_reg, used_next;
    logic [1:0]     new_cnt, wr_cnt;
    logic           pop;

    assign cfg_ready = 1'b1;
    assign cfg_req   = cfg_valid & cfg_ready;

    // Space is reserved in the queue for every result still in flight
    assign s_ready = (used_reg <= (QAW+1)'(DEPTH - 2));
    assign in_req  = s_valid & s_ready;

    // Next position in raster order
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_req) begin
            if (col_reg == last_reg) begin
                col_next = '0;
                row_next = (row_reg == last_reg) ? '0 : row_reg + ADDR_W'(1);
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
        if (cfg_req && cfg_index == egd_pkg::REG_GRID_N) begin
            col_next = '0;
            row_next = '0;
        end
    end

    // Configuration registers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= last_of(egd_pkg::GRID_N_RESET);
            rate_reg <= egd_pkg::RATE_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_req && cfg_index == egd_pkg::REG_GRID_N) begin
                last_reg <= last_of(cfg_data[egd_pkg::GRID_N_W-1:0]);
            end
            if (cfg_req && cfg_index == egd_pkg::REG_RATE) begin
                rate_reg <= cfg_data[RW-1:0];
            end
        end
    end

    // Line buffers by row parity: the current row's bank is read (row two up) and
    // written at the column; the other bank (row one up) is read one column ahead.
    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic             bank_cur;
        logic [ADDR_W-1:0] raddr;
        assign bank_cur = (row_reg[0] == 1'(b));
        assign raddr    = bank_cur ? col_reg : col_reg + ADDR_W'(1);
        egd_ram #(
            .WIDTH (VW),
            .DEPTH (STRIDE)
        ) u_bank (
            .aclk  (aclk),
            .we    (in_req & bank_cur),
            .waddr (col_reg),
            .wdata (s_cell_value),
            .raddr (raddr),
            .rdata (rdata[b])
        );
    end

    // Stage 0 -> 1: classify the request's results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_req;
        end
        if (in_req) begin
            s1_has_reg    <= (row_reg != '0);
            s1_border_reg <= (row_reg == ADDR_W'(1)) || (col_reg == '0) || (col_reg == last_reg);
            s1_emit2_reg  <= (row_reg == last_reg);
            s1_flast_reg  <= (col_reg == last_reg);
            s1_col0_reg   <= (col_reg == '0);
            s1_par_reg    <= row_reg[0];
            s1_x_reg      <= s_cell_value;
            s1_first_reg  <= first_reg;
            if (col_reg == '0) begin
                first_reg <= s_cell_value;
            end
        end
    end

    // Stage 1: stencil window and Laplacian
    assign up_val    = rdata[s1_par_reg];
    assign right_val = rdata[~s1_par_reg];
    assign cen_val   = s1_col0_reg ? s1_first_reg : win_c_reg;
    assign lap_val   = LAP_W'(signed'(win_l_reg)) + LAP_W'(signed'(right_val))
                     + LAP_W'(signed'(up_val)) + LAP_W'(signed'(s1_x_reg))
                     - (LAP_W'(signed'(cen_val)) <<< 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s1_valid_reg) begin
            win_l_reg     <= cen_val;
            win_c_reg     <= right_val;
            s2_lap_reg    <= lap_val;
            s2_c_reg      <= cen_val;
            s2_x_reg      <= s1_x_reg;
            s2_has_reg    <= s1_has_reg;
            s2_border_reg <= s1_border_reg;
            s2_emit2_reg  <= s1_emit2_reg;
            s2_flast_reg  <= s1_flast_reg;
        end
    end

    // Stage 2: scale by the rate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
        s3_prod_reg   <= PROD_W'(s2_lap_reg * signed'({1'b0, rate_reg}));
        s3_c_reg      <= s2_c_reg;
        s3_x_reg      <= s2_x_reg;
        s3_has_reg    <= s2_has_reg;
        s3_border_reg <= s2_border_reg;
        s3_emit2_reg  <= s2_emit2_reg;
        s3_flast_reg  <= s2_flast_reg;
    end

    // Stage 3: round to Q16.16, half toward plus infinity
    assign rnd_val = s3_prod_reg + PROD_W'(2048);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s3_valid_reg;
        end
        s4_q_reg      <= rnd_val[PROD_W-1:12];
        s4_c_reg      <= s3_c_reg;
        s4_x_reg      <= s3_x_reg;
        s4_has_reg    <= s3_has_reg;
        s4_border_reg <= s3_border_reg;
        s4_emit2_reg  <= s3_emit2_reg;
        s4_flast_reg  <= s3_flast_reg;
    end

    // Stage 4: add the center and saturate to 32 bits; border cells pass the center through
    assign sum_val = SUM_W'(signed'(s4_c_reg)) + SUM_W'(s4_q_reg);

    always_comb begin
        if (sum_val > SUM_W'(signed'({1'b0, {(VW-1){1'b1}}}))) begin
            sat_val = {1'b0, {(VW-1){1'b1}}};
        end else if (sum_val < SUM_W'(signed'({1'b1, {(VW-1){1'b0}}}))) begin
            sat_val = {1'b1, {(VW-1){1'b0}}};
        end else begin
            sat_val = sum_val[VW-1:0];
        end
    end

    assign res_val = s4_border_reg ? s4_c_reg : sat_val;

    // Output queue bookkeeping
    assign pop     = m_valid & m_ready;
    assign new_cnt = in_req ? (2'((row_reg != '0)) + 2'((row_reg == last_reg))) : 2'd0;
    assign wr_cnt  = s4_valid_reg ? (2'(s4_has_reg) + 2'(s4_emit2_reg)) : 2'd0;
    assign wr_ptr2 = wr_ptr_reg + QAW'(s4_has_reg);

    always_comb begin
        used_next = used_reg + (QAW+1)'(new_cnt) - (QAW+1)'(pop);
        occ_next  = occ_reg + (QAW+1)'(wr_cnt) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            occ_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            used_reg   <= used_next;
            occ_reg    <= occ_next;
            wr_ptr_reg <= wr_ptr_reg + QAW'(wr_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    // Queue storage: the stencil result first, then the bottom border cell
    always_ff @(posedge aclk) begin
        if (s4_valid_reg && s4_has_reg) begin
            q_val_reg[wr_ptr_reg]  <= res_val;
            q_last_reg[wr_ptr_reg] <= 1'b0;
        end
        if (s4_valid_reg && s4_emit2_reg) begin
            q_val_reg[wr_ptr2]  <= s4_x_reg;
            q_last_reg[wr_ptr2] <= s4_flast_reg;
        end
    end

    assign m_valid      = (occ_reg != '0);
    assign m_new_value  = q_val_reg[rd_ptr_reg];
    assign m_frame_last = q_last_reg[rd_ptr_reg];

endmodule
